>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/sues_pkg.sv
package sues_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic        pre_open;
    logic        pre_close;
    logic        is_ascii;
    logic        post_close;
    logic [15:0] unit;
  } job_t;

  typedef enum logic [2:0] {
    ST_PRE  = 3'b001,
    ST_BODY = 3'b010,
    ST_POST = 3'b100
  } phase_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_OPEN   = 8'h32;
  localparam logic [7:0] CH_CLOSE  = 8'h30;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic logic [7:0] tag_byte(input logic [1:0] idx, input logic [7:0] kind);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = CH_BSLASH;
      2'd1: r = CH_X;
      2'd2: r = kind;
      2'd3: r = CH_BSLASH;
      default: r = CH_BSLASH;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/sues_front.sv
`include "assert_macros.svh"

module sues_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  sues_pkg::in_word_t in_data,
  output sues_pkg::job_t    job
);
  import sues_pkg::*;

  logic esc_r, esc_nxt;
  logic ascii;

  always_comb begin
    ascii          = (in_data.code_unit[15:7] == 9'd0) && (in_data.code_unit[6:0] != 7'd0);
    job.pre_close  = ascii & esc_r;
    job.pre_open   = ~ascii & ~esc_r;
    job.is_ascii   = ascii;
    job.post_close = in_data.last_unit & ~ascii;
    job.unit       = in_data.code_unit;
    esc_nxt        = esc_r;
    if (acc) begin
      esc_nxt = ~ascii & ~in_data.last_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else begin
      esc_r <= esc_nxt;
    end
  end

  `ASSERT_NEXT(a_last_closes, acc && in_data.last_unit, !esc_r)
  `ASSERT_IMPL(a_open_xor_close, acc, !(job.pre_open && job.pre_close))

endmodule

>>> hw/rtl/sues_fifo.sv
`include "assert_macros.svh"

module sues_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sues_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sues_pkg::job_t rdata
);
  import sues_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == QCW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wp_nxt  = do_push ? ((wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop  ? ((rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + QCW'(do_push) - QCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  `ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= QCW'(QDEPTH))
  `ASSERT_IMPL(a_ptr_match, (cnt_r == '0) || (cnt_r == QCW'(QDEPTH)), wp_r == rp_r)

endmodule

>>> hw/rtl/sues_back.sv
`include "assert_macros.svh"

module sues_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_empty,
  input  sues_pkg::job_t     job,
  output logic               job_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output sues_pkg::out_word_t out_data
);
  import sues_pkg::*;

  phase_t     phase_r, phase_nxt, eff;
  logic [1:0] cnt_r, cnt_nxt;
  out_word_t  data_r, data_nxt;
  logic       vld_r, vld_nxt;
  logic       ld, seg_end, job_done;
  logic [7:0] byt;
  logic [3:0] nib;

  assign ld = ~job_empty & (~vld_r | out_pop);

  always_comb begin
    eff = phase_r;
    if (phase_r == ST_PRE && !(job.pre_open || job.pre_close)) begin
      eff = ST_BODY;
    end
    unique case (cnt_r)
      2'd0: nib = job.unit[15:12];
      2'd1: nib = job.unit[11:8];
      2'd2: nib = job.unit[7:4];
      2'd3: nib = job.unit[3:0];
      default: nib = job.unit[3:0];
    endcase
    byt      = CH_BSLASH;
    seg_end  = 1'b0;
    job_done = 1'b0;
    unique case (eff)
      ST_PRE: begin
        byt     = tag_byte(cnt_r, job.pre_open ? CH_OPEN : CH_CLOSE);
        seg_end = (cnt_r == 2'd3);
      end
      ST_BODY: begin
        byt      = job.is_ascii ? job.unit[7:0] : hex_char(nib);
        seg_end  = job.is_ascii | (cnt_r == 2'd3);
        job_done = seg_end & ~job.post_close;
      end
      ST_POST: begin
        byt      = tag_byte(cnt_r, CH_CLOSE);
        seg_end  = (cnt_r == 2'd3);
        job_done = seg_end;
      end
      default: begin
        byt = CH_BSLASH;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    data_nxt  = data_r;
    vld_nxt   = vld_r & ~out_pop;
    job_pop   = 1'b0;
    if (ld) begin
      data_nxt.out_byte    = byt;
      data_nxt.last_of_run = job_done;
      vld_nxt              = 1'b1;
      if (seg_end) begin
        cnt_nxt = 2'd0;
        if (job_done) begin
          phase_nxt = ST_PRE;
          job_pop   = 1'b1;
        end else if (eff == ST_PRE) begin
          phase_nxt = ST_BODY;
        end else begin
          phase_nxt = ST_POST;
        end
      end else begin
        cnt_nxt   = cnt_r + 2'd1;
        phase_nxt = eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ST_PRE;
      cnt_r   <= 2'd0;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_empty = ~vld_r;
  assign out_data  = data_r;

  `ASSERT_NEXT(a_done_rewinds, ld && job_done, phase_r == ST_PRE && cnt_r == 2'd0)
  `ASSERT_IMPL(a_pop_on_done, job_pop, ld && job_done)

endmodule

>>> hw/rtl/step_unicode_string_escaper_top.sv
// An accepted item goes into the job queue, then its first byte into the output byte
// register. Throughput: one byte per cycle while out_pop is high and jobs are queued;
// an item yields 1 to 12 bytes, set by the back-end byte sequencer.
// A two-entry job queue lets the front keep accepting while bytes drain.
// Reset (synchronous, rst_n low): escape flag cleared, queue and sequencer emptied.
module step_unicode_string_escaper_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  sues_pkg::in_word_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output sues_pkg::out_word_t out_data
);
  import sues_pkg::*;

  job_t f_job, q_job;
  logic acc, q_empty, q_pop;

  assign acc = in_push & ~in_full;

  sues_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .job     (f_job)
  );

  sues_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (f_job),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_job)
  );

  sues_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (q_empty),
    .job       (q_job),
    .job_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
